@@ rtl/ufbd_pkg.sv @@
// Shared widths, constants and sequencer states of the fractional baud divider.
package ufbd_pkg;

  localparam int unsigned PCLK_W = 27;
  localparam int unsigned BAUD_W = 23;
  localparam int unsigned DIV_W = 16;
  localparam int unsigned FRAC_W = 4;
  localparam int unsigned SEL_W = 2;

  localparam int unsigned FRACTION_LIMIT = 15;
  localparam logic [PCLK_W-1:0] SYS_CLK_RESET = PCLK_W'(72000000);

  localparam logic [SEL_W-1:0] SEL_FULL = 2'd1;
  localparam logic [SEL_W-1:0] SEL_HALF = 2'd2;
  localparam logic [SEL_W-1:0] SEL_EIGHTH = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_BAUD,
    ST_SETUP,
    ST_LOAD,
    ST_DIV_PAIR,
    ST_COMPARE,
    ST_DONE
  } state_t;

endpackage

@@ rtl/uart_fractional_baud_divider_core.sv @@
// Top level of the UART fractional baud divider: divide and add/multiply search.
//
// Usage: write the core clock in hertz through system_clock_we/system_clock_hz
// while the block is idle (reset value 72 MHz). Raise start with clock_select
// and baud_rate; the request is taken at an edge where start is high and busy
// is low. busy then stays high until the result is shown.
// The result appears on divisor_latch, divide_add, multiply_value and
// divisor_overflow for exactly one cycle, marked by done; the receiver
// cannot stall, so it must take the result in that cycle.
// One bit-serial restoring divider, 31 steps a pass, does all the
// division. The integer divide is one pass plus a setup state.
// Each add/multiply pair tried is a load with the product, a divide pass
// and a compare. The inner loop over multiply values exits early once the
// difference grows; a zero baud rate skips the division and an exact
// divisor skips the pair search.
// One request is processed at a time.
// Reset returns the sequencer to idle and the clock register to 72 MHz.
module uart_fractional_baud_divider_core #(
  parameter int unsigned FRACTION_LIMIT = ufbd_pkg::FRACTION_LIMIT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          system_clock_we,
  input  logic [ufbd_pkg::PCLK_W-1:0]   system_clock_hz,
  input  logic                          start,
  output logic                          busy,
  input  logic [ufbd_pkg::SEL_W-1:0]    clock_select,
  input  logic [ufbd_pkg::BAUD_W-1:0]   baud_rate,
  output logic                          done,
  output logic [ufbd_pkg::DIV_W-1:0]    divisor_latch,
  output logic [ufbd_pkg::FRAC_W-1:0]   divide_add,
  output logic [ufbd_pkg::FRAC_W-1:0]   multiply_value,
  output logic                          divisor_overflow
);

  localparam int unsigned PW = ufbd_pkg::PCLK_W;
  localparam int unsigned BW = ufbd_pkg::BAUD_W;
  localparam int unsigned FW = ufbd_pkg::FRAC_W;
  localparam int unsigned QW = PW + FW;
  localparam int unsigned CNT_W = $clog2(QW);
  localparam logic [FW-1:0] LIMIT = FW'(FRACTION_LIMIT);

  ufbd_pkg::state_t state, state_next;

  logic [PW-1:0]    clk_hz_cfg;
  logic [PW-1:0]    pclk;
  logic [PW-1:0]    rem;
  logic [PW-1:0]    prod;
  logic [PW-1:0]    best;
  logic [FW-1:0]    add_cnt;
  logic [FW-1:0]    mul_cnt;
  logic [QW-1:0]    quo;
  logic [BW-1:0]    part;
  logic [BW-1:0]    dvsr;
  logic [CNT_W-1:0] step_cnt;

  logic [PW-1:0]    pclk_sel;
  logic [BW:0]      shift_r;
  logic [BW+1:0]    trial;
  logic             ge;
  logic [BW-1:0]    part_next;
  logic [QW-1:0]    quo_next;
  logic [PW-1:0]    rem_calc;
  logic [QW-1:0]    diff;
  logic             diff_gt;
  logic             diff_lt;
  logic             accept;

  assign accept = start && !busy;

  always_comb begin
    unique case (clock_select)
      ufbd_pkg::SEL_FULL:   pclk_sel = clk_hz_cfg;
      ufbd_pkg::SEL_HALF:   pclk_sel = clk_hz_cfg >> 1;
      ufbd_pkg::SEL_EIGHTH: pclk_sel = clk_hz_cfg >> 3;
      default:              pclk_sel = clk_hz_cfg >> 2;
    endcase
  end

  // Restoring divide step.
  always_comb begin
    shift_r = {part, quo[QW-1]};
    trial = {1'b0, shift_r} - {2'b00, dvsr};
    ge = !trial[BW+1];
    part_next = ge ? trial[BW-1:0] : shift_r[BW-1:0];
    quo_next = {quo[QW-2:0], ge};
  end

  assign rem_calc = {part[PW-5:0], pclk[3:0]};
  assign diff = (quo > QW'(rem)) ? (quo - QW'(rem)) : (QW'(rem) - quo);
  assign diff_gt = diff > QW'(best);
  assign diff_lt = diff < QW'(best);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ufbd_pkg::ST_IDLE;
      clk_hz_cfg <= ufbd_pkg::SYS_CLK_RESET;
    end else begin
      state <= state_next;
      if (system_clock_we) begin
        clk_hz_cfg <= system_clock_hz;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ufbd_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (baud_rate == '0) ? ufbd_pkg::ST_DONE : ufbd_pkg::ST_DIV_BAUD;
        end
      end
      ufbd_pkg::ST_DIV_BAUD: begin
        if (step_cnt == '0) begin
          state_next = ufbd_pkg::ST_SETUP;
        end
      end
      ufbd_pkg::ST_SETUP: begin
        state_next = (rem_calc == '0) ? ufbd_pkg::ST_DONE : ufbd_pkg::ST_LOAD;
      end
      ufbd_pkg::ST_LOAD: state_next = ufbd_pkg::ST_DIV_PAIR;
      ufbd_pkg::ST_DIV_PAIR: begin
        if (step_cnt == '0) begin
          state_next = ufbd_pkg::ST_COMPARE;
        end
      end
      ufbd_pkg::ST_COMPARE: begin
        if ((diff_gt || mul_cnt == FW'(1)) && add_cnt == LIMIT) begin
          state_next = ufbd_pkg::ST_DONE;
        end else begin
          state_next = ufbd_pkg::ST_LOAD;
        end
      end
      ufbd_pkg::ST_DONE: state_next = ufbd_pkg::ST_IDLE;
      default: state_next = ufbd_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state != ufbd_pkg::ST_IDLE);
  assign done = (state == ufbd_pkg::ST_DONE);

  always_ff @(posedge clk) begin
    case (state)
      ufbd_pkg::ST_IDLE: begin
        pclk <= pclk_sel;
        quo <= QW'(pclk_sel[PW-1:4]);
        part <= '0;
        dvsr <= baud_rate;
        step_cnt <= CNT_W'(QW - 1);
        divide_add <= '0;
        multiply_value <= FW'(1);
        divisor_latch <= '1;
        divisor_overflow <= 1'b1;
      end
      ufbd_pkg::ST_DIV_BAUD, ufbd_pkg::ST_DIV_PAIR: begin
        quo <= quo_next;
        part <= part_next;
        step_cnt <= step_cnt - CNT_W'(1);
      end
      ufbd_pkg::ST_SETUP: begin
        rem <= rem_calc;
        best <= rem_calc;
        prod <= pclk - rem_calc;
        divisor_overflow <= |quo[BW-1:ufbd_pkg::DIV_W];
        divisor_latch <= (|quo[BW-1:ufbd_pkg::DIV_W]) ? '1 : quo[ufbd_pkg::DIV_W-1:0];
        add_cnt <= FW'(1);
        mul_cnt <= LIMIT;
      end
      ufbd_pkg::ST_LOAD: begin
        quo <= QW'(prod) * QW'(add_cnt);
        part <= '0;
        dvsr <= BW'(mul_cnt);
        step_cnt <= CNT_W'(QW - 1);
      end
      ufbd_pkg::ST_COMPARE: begin
        if (!diff_gt && diff_lt) begin
          best <= diff[PW-1:0];
          divide_add <= add_cnt;
          multiply_value <= mul_cnt;
        end
        if (diff_gt || mul_cnt == FW'(1)) begin
          add_cnt <= add_cnt + FW'(1);
          mul_cnt <= LIMIT;
        end else begin
          mul_cnt <= mul_cnt - FW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
      (start && !busy) |=> busy)
    else $error("request taken without going busy");

  a_mul_nonzero: assert property (@(posedge clk) disable iff (rst)
      done |-> (multiply_value != '0))
    else $error("multiply value of zero reported");

  a_overflow_sat: assert property (@(posedge clk) disable iff (rst)
      (done && divisor_overflow) |-> (divisor_latch == '1))
    else $error("overflow reported without saturated divisor");

  a_add_range: assert property (@(posedge clk) disable iff (rst)
      done |-> (divide_add <= LIMIT))
    else $error("add value beyond fraction limit");

endmodule

@@ test/tb_top.sv @@
// Testbench for the fractional baud divider: directed table, then random requests checked by a predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ufbd_pkg::SEL_W-1:0] SEL_QUARTER = 2'd0;
  localparam int unsigned WATCHDOG_LIMIT = 40000;
  localparam int unsigned TAIL_CYCLES = 16;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned ITEMS_PER_PHASE = 100;
  localparam int unsigned NUM_PHASES = 6;
  localparam int unsigned DRAIN_EVERY = 40;
  localparam logic [ufbd_pkg::PCLK_W-1:0] PCLK_ALL_ONES = '1;
  localparam logic [ufbd_pkg::BAUD_W-1:0] BAUD_ALL_ONES = '1;

  typedef struct packed {
    logic [ufbd_pkg::DIV_W-1:0]  latch;
    logic [ufbd_pkg::FRAC_W-1:0] add;
    logic [ufbd_pkg::FRAC_W-1:0] mul;
    logic                        ovf;
  } baud_setting_t;

  typedef enum logic {ROW_CLOCK, ROW_REQUEST} row_kind_t;

  typedef struct {
    row_kind_t                   kind;
    logic [ufbd_pkg::SEL_W-1:0]  sel;
    logic [ufbd_pkg::PCLK_W-1:0] value;
    bit                          typed;
    baud_setting_t               want;
  } row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        clock_hz_we = 1'b0;
  logic [ufbd_pkg::PCLK_W-1:0] clock_hz_wr = '0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [ufbd_pkg::SEL_W-1:0]  clock_select = SEL_QUARTER;
  logic [ufbd_pkg::BAUD_W-1:0] baud_rate = '0;
  logic                        done;
  logic [ufbd_pkg::DIV_W-1:0]  divisor_latch;
  logic [ufbd_pkg::FRAC_W-1:0] divide_add;
  logic [ufbd_pkg::FRAC_W-1:0] multiply_value;
  logic                        divisor_overflow;

  bit                          typed_pending = 1'b0;
  baud_setting_t               typed_setting = '0;
  logic [ufbd_pkg::PCLK_W-1:0] core_hz_model = ufbd_pkg::SYS_CLK_RESET;
  baud_setting_t               pending_settings[$];
  row_t                        directed_rows[$];
  int unsigned                 requests_taken = 0;
  int unsigned                 quiet_cycles = 0;
  int unsigned                 mismatches = 0;

  uart_fractional_baud_divider_core dut (
    .clk              (clk),
    .rst              (rst),
    .system_clock_we  (clock_hz_we),
    .system_clock_hz  (clock_hz_wr),
    .start            (start),
    .busy             (busy),
    .clock_select     (clock_select),
    .baud_rate        (baud_rate),
    .done             (done),
    .divisor_latch    (divisor_latch),
    .divide_add       (divide_add),
    .multiply_value   (multiply_value),
    .divisor_overflow (divisor_overflow)
  );

  always #4 clk = ~clk;

  function automatic logic [63:0] pclk_hz(logic [ufbd_pkg::PCLK_W-1:0] core_hz,
                                          logic [ufbd_pkg::SEL_W-1:0] sel);
    case (sel)
      ufbd_pkg::SEL_FULL:   return 64'(core_hz);
      ufbd_pkg::SEL_HALF:   return 64'(core_hz) / 2;
      ufbd_pkg::SEL_EIGHTH: return 64'(core_hz) / 8;
      default:              return 64'(core_hz) / 4;
    endcase
  endfunction

  function automatic baud_setting_t fractional_setting(
      logic [ufbd_pkg::PCLK_W-1:0] core_hz,
      logic [ufbd_pkg::SEL_W-1:0] sel,
      logic [ufbd_pkg::BAUD_W-1:0] baud);
    logic [63:0]   pclk;
    logic [63:0]   div;
    logic [63:0]   rem;
    logic [63:0]   best;
    logic [63:0]   corr;
    logic [63:0]   diff;
    baud_setting_t res;
    int            a;
    int            m;
    bit            stop;
    res.latch = '1;
    res.add = '0;
    res.mul = ufbd_pkg::FRAC_W'(1);
    res.ovf = 1'b1;
    if (baud == '0) return res;
    pclk = pclk_hz(core_hz, sel);
    div = (pclk / 16) / 64'(baud);
    rem = pclk - div * 64'(baud) * 16;
    best = rem;
    if (rem != 0) begin
      for (a = 1; a <= int'(ufbd_pkg::FRACTION_LIMIT); a++) begin
        stop = 1'b0;
        for (m = int'(ufbd_pkg::FRACTION_LIMIT); m >= 1 && !stop; m--) begin
          corr = 64'(baud) * 16 * div * 64'(a) / 64'(m);
          diff = (corr > rem) ? corr - rem : rem - corr;
          if (diff > best) begin
            stop = 1'b1;
          end else if (diff < best) begin
            best = diff;
            res.add = a[ufbd_pkg::FRAC_W-1:0];
            res.mul = m[ufbd_pkg::FRAC_W-1:0];
          end
        end
      end
    end
    res.ovf = div > 64'(16'hFFFF);
    res.latch = res.ovf ? '1 : div[ufbd_pkg::DIV_W-1:0];
    return res;
  endfunction

  function automatic logic [ufbd_pkg::BAUD_W-1:0] random_baud(
      logic [ufbd_pkg::PCLK_W-1:0] core_hz,
      logic [ufbd_pkg::SEL_W-1:0] sel);
    logic [63:0] lim;
    int unsigned pick;
    pick = $urandom_range(99);
    lim = pclk_hz(core_hz, sel) / 16;
    if (lim > 64'(BAUD_ALL_ONES)) lim = 64'(BAUD_ALL_ONES);
    if (pick < 4) return '0;
    if (pick < 20 || lim == 0) return ufbd_pkg::BAUD_W'($urandom);
    if (pick < 30) return ufbd_pkg::BAUD_W'($urandom_range(8000000, 1));
    if (pick < 50) return ufbd_pkg::BAUD_W'(lim / 64'($urandom_range(4000, 1)));
    return ufbd_pkg::BAUD_W'($urandom_range(32'(lim), 1));
  endfunction

  task automatic report_mismatch(input string what, input baud_setting_t want,
                                 input baud_setting_t got);
    if (mismatches < REPORT_LIMIT)
      $display({"%s: want latch %0d add %0d mul %0d ovf %0d,",
                " got latch %0d add %0d mul %0d ovf %0d"},
               what, want.latch, want.add, want.mul, want.ovf,
               got.latch, got.add, got.mul, got.ovf);
    mismatches++;
  endtask

  always @(posedge clk) begin
    baud_setting_t got;
    baud_setting_t want;
    bit            moved;
    moved = 1'b0;
    if (rst) begin
      core_hz_model <= ufbd_pkg::SYS_CLK_RESET;
    end else begin
      if (done) begin
        moved = 1'b1;
        got = '{divisor_latch, divide_add, multiply_value, divisor_overflow};
        if (pending_settings.size() == 0) begin
          report_mismatch("result with no request pending", '0, got);
        end else begin
          want = pending_settings.pop_front();
          if (got.latch !== want.latch || got.add !== want.add ||
              got.mul !== want.mul || got.ovf !== want.ovf)
            report_mismatch("mismatch", want, got);
        end
      end
      if (start && !busy) begin
        moved = 1'b1;
        pending_settings.push_back(typed_pending ? typed_setting :
                                   fractional_setting(core_hz_model, clock_select, baud_rate));
        requests_taken <= requests_taken + 1;
      end
      if (clock_hz_we) core_hz_model <= clock_hz_wr;
    end
    if (moved) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic [ufbd_pkg::SEL_W-1:0] sel,
                              input logic [ufbd_pkg::BAUD_W-1:0] baud,
                              input bit typed, input baud_setting_t want,
                              input int unsigned idle_pct);
    int unsigned target;
    target = requests_taken + 1;
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    clock_select = sel;
    baud_rate = baud;
    typed_pending = typed;
    typed_setting = want;
    while (requests_taken != target) @(negedge clk);
  endtask

  task automatic drain;
    start = 1'b0;
    while (pending_settings.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_core_hz(input logic [ufbd_pkg::PCLK_W-1:0] value);
    drain();
    clock_hz_we = 1'b1;
    clock_hz_wr = value;
    @(negedge clk);
    clock_hz_we = 1'b0;
  endtask

  task automatic add_row(input row_kind_t kind, input logic [ufbd_pkg::SEL_W-1:0] sel,
                         input int unsigned value, input bit typed,
                         input baud_setting_t want);
    row_t r;
    r.kind = kind;
    r.sel = sel;
    r.value = ufbd_pkg::PCLK_W'(value);
    r.typed = typed;
    r.want = want;
    directed_rows.push_back(r);
  endtask

  initial begin
    baud_setting_t               sat;
    baud_setting_t               zero_div;
    baud_setting_t               one_div;
    logic [ufbd_pkg::PCLK_W-1:0] phase_hz[NUM_PHASES];
    logic [ufbd_pkg::SEL_W-1:0]  sel;
    int unsigned                 idle_pct;
    sat = '{16'hFFFF, 4'd0, 4'd1, 1'b1};
    zero_div = '{16'd0, 4'd0, 4'd1, 1'b0};
    one_div = '{16'd1, 4'd0, 4'd1, 1'b0};

    add_row(ROW_REQUEST, SEL_QUARTER, 0, 1'b1, sat);
    add_row(ROW_REQUEST, ufbd_pkg::SEL_EIGHTH, 0, 1'b1, sat);
    add_row(ROW_REQUEST, ufbd_pkg::SEL_FULL, 1, 1'b1, sat);
    add_row(ROW_REQUEST, SEL_QUARTER, 1, 1'b1, sat);
    add_row(ROW_REQUEST, ufbd_pkg::SEL_EIGHTH, 1, 1'b1, sat);
    add_row(ROW_REQUEST, ufbd_pkg::SEL_HALF, 8000000, 1'b1, zero_div);
    add_row(ROW_REQUEST, ufbd_pkg::SEL_FULL, 32'(BAUD_ALL_ONES), 1'b1, zero_div);
    add_row(ROW_REQUEST, ufbd_pkg::SEL_FULL, 4500000, 1'b1, one_div);
    add_row(ROW_REQUEST, ufbd_pkg::SEL_HALF, 2250000, 1'b1, one_div);
    add_row(ROW_REQUEST, ufbd_pkg::SEL_FULL, 7, 1'b0, '0);
    add_row(ROW_REQUEST, SEL_QUARTER, 115200, 1'b0, '0);
    add_row(ROW_REQUEST, ufbd_pkg::SEL_HALF, 9600, 1'b0, '0);
    add_row(ROW_REQUEST, ufbd_pkg::SEL_EIGHTH, 300, 1'b0, '0);
    add_row(ROW_REQUEST, ufbd_pkg::SEL_FULL, 115200, 1'b0, '0);
    add_row(ROW_REQUEST, SEL_QUARTER, 19200, 1'b0, '0);
    add_row(ROW_REQUEST, ufbd_pkg::SEL_FULL, 921600, 1'b0, '0);
    add_row(ROW_REQUEST, ufbd_pkg::SEL_HALF, 3000000, 1'b0, '0);
    add_row(ROW_REQUEST, ufbd_pkg::SEL_EIGHTH, 4194304, 1'b0, '0);
    add_row(ROW_CLOCK, SEL_QUARTER, 1, 1'b0, '0);
    add_row(ROW_REQUEST, SEL_QUARTER, 1, 1'b1, zero_div);
    add_row(ROW_REQUEST, ufbd_pkg::SEL_FULL, 1, 1'b1, zero_div);
    add_row(ROW_CLOCK, SEL_QUARTER, 32'(PCLK_ALL_ONES), 1'b0, '0);
    add_row(ROW_REQUEST, ufbd_pkg::SEL_FULL, 1, 1'b0, '0);
    add_row(ROW_REQUEST, ufbd_pkg::SEL_EIGHTH, 5, 1'b0, '0);
    add_row(ROW_CLOCK, SEL_QUARTER, 0, 1'b0, '0);
    add_row(ROW_REQUEST, ufbd_pkg::SEL_FULL, 3, 1'b1, zero_div);

    phase_hz[0] = ufbd_pkg::PCLK_W'(120000000);
    phase_hz[1] = ufbd_pkg::SYS_CLK_RESET;
    phase_hz[2] = ufbd_pkg::PCLK_W'($urandom_range(120000000, 1));
    phase_hz[3] = PCLK_ALL_ONES;
    phase_hz[4] = ufbd_pkg::PCLK_W'($urandom);
    phase_hz[5] = ufbd_pkg::PCLK_W'($urandom_range(120000000, 1000000));

    repeat (8) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CLOCK)
        write_core_hz(directed_rows[i].value);
      else
        send_request(directed_rows[i].sel, directed_rows[i].value[ufbd_pkg::BAUD_W-1:0],
                     directed_rows[i].typed, directed_rows[i].want, 0);
    end

    for (int p = 0; p < int'(NUM_PHASES); p++) begin
      write_core_hz(phase_hz[p]);
      idle_pct = (p < 2) ? 15 : (p < 4) ? 47 : 0;
      for (int n = 0; n < int'(ITEMS_PER_PHASE); n++) begin
        if (n % DRAIN_EVERY == DRAIN_EVERY - 1) drain();
        sel = ufbd_pkg::SEL_W'($urandom);
        send_request(sel, random_baud(phase_hz[p], sel), 1'b0, '0, idle_pct);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_settings.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/ufbd_pkg.sv
rtl/uart_fractional_baud_divider_core.sv
test/tb_top.sv
